### rtl/fr_pkg.sv
// Package for the fraction reducer: field widths and the packed request and
// result types. No dependencies; used by fraction_reduce and the testbench.
package fr_pkg;

  localparam int unsigned Width = 32;
  localparam int unsigned MagW  = Width - 1;

  typedef struct packed {
    logic signed [Width-1:0] numer_in;
    logic signed [Width-1:0] denom_in;
  } fr_in_t;

  typedef struct packed {
    logic signed [Width-1:0] numer_out;
    logic [MagW-1:0]         denom_out;
    logic                    both_zero;
  } fr_out_t;

endpackage

### rtl/fr_div.sv
// Bit-serial restoring divider: one quotient bit per cycle through a shift
// register. No package dependency; instantiated by fraction_reduce.
module fr_div #(
  parameter int unsigned W = 31
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(W + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [W-1:0]    dq_q, dq_d;
  logic [W-1:0]    dsr_q, dsr_d;
  logic [W:0]      rem_sh;
  logic [W:0]      diff;

  assign rem_sh = {rem_q, dq_q[W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    dq_d   = dq_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CntW'(W);
      rem_d = '0;
      dq_d  = dividend_i;
      dsr_d = divisor_i;
    end else if (run_q) begin
      if (diff[W]) begin
        rem_d = rem_sh[W-1:0];
        dq_d  = {dq_q[W-2:0], 1'b0};
      end else begin
        rem_d = diff[W-1:0];
        dq_d  = {dq_q[W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

### rtl/fraction_reduce.sv
// Top level of the fraction reducer: binary GCD sequencer and output register.
// Depends on fr_pkg for widths and payload types and on fr_div for division.
//
// A request transfers when start is high and busy is low. The block takes
// the magnitudes (the most negative input saturates to the largest positive
// magnitude), finds their GCD with a binary GCD that does one shift or one
// subtract per cycle (common factors of two are first stripped one at a time
// and the GCD is scaled back by them afterwards), and then divides both
// magnitudes by it on one shared bit-serial divider. Two zero inputs are
// answered directly from the idle state. The result is presented for
// one cycle with done_o high and must be taken then; busy drops in that same
// cycle, so the next request can transfer while the result is shown.
module fraction_reduce (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  fr_pkg::fr_in_t  req_i,
  output logic          busy,
  output logic          done_o,
  output fr_pkg::fr_out_t res_o
);

  localparam int unsigned W  = fr_pkg::Width;
  localparam int unsigned M  = fr_pkg::MagW;
  localparam int unsigned KW = $clog2(W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMMON,
    S_REDUCE,
    S_SCALE,
    S_DIVN_GO,
    S_DIVN_WAIT,
    S_DIVD_GO,
    S_DIVD_WAIT
  } state_e;

  state_e          state_q, state_d;
  logic [M-1:0]    a_q, a_d;
  logic [M-1:0]    b_q, b_d;
  logic [M-1:0]    nm_q, nm_d;
  logic [M-1:0]    dm_q, dm_d;
  logic [M-1:0]    qn_q, qn_d;
  logic [KW-1:0]   k_q, k_d;
  logic            neg_q, neg_d;
  logic            done_q, done_d;
  fr_pkg::fr_out_t res_q, res_d;

  logic [W-1:0] n_raw, d_raw, n_abs, d_abs;
  logic [M-1:0] n_mag, d_mag;
  logic [M:0]   ab_diff;
  logic         div_start;
  logic [M-1:0] div_dividend;
  logic         div_done;
  logic [M-1:0] div_quot;
  logic [W-1:0] numer_pos;

  assign n_raw = W'(req_i.numer_in);
  assign d_raw = W'(req_i.denom_in);
  assign n_abs = n_raw[W-1] ? (~n_raw + W'(1)) : n_raw;
  assign d_abs = d_raw[W-1] ? (~d_raw + W'(1)) : d_raw;
  assign n_mag = n_abs[W-1] ? {M{1'b1}} : n_abs[M-1:0];
  assign d_mag = d_abs[W-1] ? {M{1'b1}} : d_abs[M-1:0];

  assign ab_diff = {1'b0, a_q} - {1'b0, b_q};

  assign div_start    = (state_q == S_DIVN_GO) || (state_q == S_DIVD_GO);
  assign div_dividend = (state_q == S_DIVN_GO) ? nm_q : dm_q;

  fr_div #(
    .W (M)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (a_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign numer_pos = {1'b0, qn_q};

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    nm_d    = nm_q;
    dm_d    = dm_q;
    qn_d    = qn_q;
    k_d     = k_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          nm_d  = n_mag;
          dm_d  = d_mag;
          a_d   = n_mag;
          b_d   = d_mag;
          k_d   = '0;
          neg_d = n_raw[W-1] ^ d_raw[W-1];
          if ((n_mag == '0) && (d_mag == '0)) begin
            done_d          = 1'b1;
            res_d.numer_out = '0;
            res_d.denom_out = '0;
            res_d.both_zero = 1'b1;
          end else begin
            state_d = S_COMMON;
          end
        end
      end
      S_COMMON: begin
        if (!a_q[0] && !b_q[0]) begin
          a_d = a_q >> 1;
          b_d = b_q >> 1;
          k_d = k_q + KW'(1);
        end else begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        priority if (a_q == '0) begin
          a_d     = b_q;
          state_d = S_SCALE;
        end else if (b_q == '0) begin
          state_d = S_SCALE;
        end else if (!a_q[0]) begin
          a_d = a_q >> 1;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (!ab_diff[M]) begin
          a_d = ab_diff[M-1:0];
        end else begin
          b_d = b_q - a_q;
        end
      end
      S_SCALE: begin
        if (k_q == '0) begin
          state_d = S_DIVN_GO;
        end else begin
          a_d = a_q << 1;
          k_d = k_q - KW'(1);
        end
      end
      S_DIVN_GO: begin
        state_d = S_DIVN_WAIT;
      end
      S_DIVN_WAIT: begin
        if (div_done) begin
          qn_d    = div_quot;
          state_d = S_DIVD_GO;
        end
      end
      S_DIVD_GO: begin
        state_d = S_DIVD_WAIT;
      end
      S_DIVD_WAIT: begin
        if (div_done) begin
          done_d          = 1'b1;
          res_d.numer_out = neg_q ? (~numer_pos + W'(1)) : numer_pos;
          res_d.denom_out = div_quot;
          res_d.both_zero = 1'b0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    nm_q  <= nm_d;
    dm_q  <= dm_d;
    qn_q  <= qn_d;
    k_q   <= k_d;
    neg_q <= neg_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### tb/fraction_reduce_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fraction_reduce: drives directed and random fractions
// through the start/busy command port and checks every done_o result against its own
// lowest-terms calculation. Depends on fr_pkg and on the fraction_reduce RTL only.
module testbench;

  localparam int unsigned Width = fr_pkg::Width;
  localparam int unsigned MagW  = fr_pkg::MagW;

  typedef logic signed [Width-1:0] word_t;

  localparam int unsigned RandomItems = 800;
  localparam int unsigned TailItems   = 150;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DirCount    = 22;

  localparam word_t MostNeg = {1'b1, {(Width-1){1'b0}}};
  localparam word_t MostPos = {1'b0, {(Width-1){1'b1}}};

  localparam word_t DirNumer [DirCount] = '{
    0, 0, 0, 7, -7, MostNeg, MostNeg, 0, MostPos, MostPos, -MostPos,
    6, -6, 12, 1, -1, MostPos, 1, MostNeg, MostNeg, 1 << 30, -15015
  };
  localparam word_t DirDenom [DirCount] = '{
    0, 5, -5, 0, 0, MostNeg, 0, MostNeg, MostPos, -MostPos, MostNeg,
    -4, -4, 18, 1, -1, 1, -MostPos, 2, -1, 1 << 29, 1190
  };

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  fr_pkg::fr_in_t  req_i;
  logic            busy;
  logic            done_o;
  fr_pkg::fr_out_t res_o;

  int unsigned cycles;
  int unsigned sent;

  fraction_reduce dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  // Magnitude of a signed word; the most negative value saturates to the largest one.
  function automatic longint unsigned magnitude(word_t v, output bit neg);
    logic [Width-1:0] m;
    neg = v[Width-1];
    if (v == MostNeg) begin
      m = MostPos;
    end else begin
      m = neg ? -v : v;
    end
    return 64'(m);
  endfunction

  function automatic fr_pkg::fr_out_t reduce_fraction(fr_pkg::fr_in_t req);
    fr_pkg::fr_out_t res;
    longint unsigned nm, dm, x, y, r, rn, rd;
    bit nneg, dneg, rneg;
    nm = magnitude(req.numer_in, nneg);
    dm = magnitude(req.denom_in, dneg);
    res = '0;
    if (nm == 0 && dm == 0) begin
      res.both_zero = 1'b1;
      return res;
    end
    if (nm == 0) begin
      res.denom_out = MagW'(1);
      return res;
    end
    if (dm == 0) begin
      rn = 1;
      rd = 0;
      rneg = nneg;
    end else begin
      x = nm;
      y = dm;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      rn = nm / x;
      rd = dm / x;
      rneg = nneg != dneg;
    end
    res.numer_out = word_t'(rneg ? (~rn + 1) : rn);
    res.denom_out = rd[MagW-1:0];
    return res;
  endfunction

  class FractionBoard;
    fr_pkg::fr_out_t pending_fractions[$];
    int unsigned     mismatches;
    int unsigned     reduced;
    int unsigned     zero_pairs;

    function void note_request(fr_pkg::fr_in_t req);
      pending_fractions.push_back(reduce_fraction(req));
    endfunction

    function void check_result(fr_pkg::fr_out_t got);
      fr_pkg::fr_out_t want;
      if (pending_fractions.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] result %0d/%0d zero=%0b with no request outstanding",
                   $realtime, got.numer_out, got.denom_out, got.both_zero);
        end
        return;
      end
      want = pending_fractions.pop_front();
      reduced++;
      if (want.both_zero) begin
        zero_pairs++;
      end
      if (got.numer_out !== want.numer_out || got.denom_out !== want.denom_out ||
          got.both_zero !== want.both_zero) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("[%0t] expected %0d/%0d zero=%0b, got %0d/%0d zero=%0b", $realtime,
                   want.numer_out, want.denom_out, want.both_zero,
                   got.numer_out, got.denom_out, got.both_zero);
        end
      end
    endfunction
  endclass

  FractionBoard board;

  initial begin
    clk_i = 1'b0;
    board = new();
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Results are checked before the request of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        board.check_result(res_o);
      end
      if (start && !busy) begin
        board.note_request(req_i);
      end
    end
  end

  // Entered at a falling edge; returns at the falling edge after the transfer.
  task automatic send_fraction(word_t numer, word_t denom, bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    req_i.numer_in = numer;
    req_i.denom_in = denom;
    start = 1'b1;
    do begin
      @(posedge clk_i);
    end while (busy);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic word_t random_operand();
    longint unsigned v;
    v = 0;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = longint'($urandom_range(0, 40)) - 20;
      2: v = MostNeg;
      3: v = $urandom_range(0, 1) ? MostPos : -MostPos;
      4, 5, 6: v = $urandom;
      default: begin
        v = $urandom >> $urandom_range(0, 30);
        if ($urandom_range(0, 1)) begin
          v = -v;
        end
      end
    endcase
    return word_t'(v);
  endfunction

  task automatic send_random_fraction(bit allow_idle);
    longint g, a, b;
    word_t numer, denom;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        g = $urandom_range(1, 1 << 14);
        a = $urandom_range(0, 1 << 16);
        b = $urandom_range(0, 1 << 16);
        numer = word_t'($urandom_range(0, 1) ? -(a * g) : a * g);
        denom = word_t'($urandom_range(0, 1) ? -(b * g) : b * g);
      end
      4: begin
        numer = word_t'(longint'($urandom_range(1, 7)) << $urandom_range(0, 28));
        denom = word_t'(-(longint'($urandom_range(1, 7)) << $urandom_range(0, 28)));
      end
      default: begin
        numer = random_operand();
        denom = random_operand();
      end
    endcase
    send_fraction(numer, denom, allow_idle);
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    sent = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      send_fraction(DirNumer[i], DirDenom[i], $urandom_range(0, 1));
    end
    for (int i = 0; i < RandomItems; i++) begin
      send_random_fraction(i < RandomItems - TailItems);
    end
    start = 1'b0;

    while (board.pending_fractions.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d fractions (%0d directed edge cases, the rest random with shared factors,",
             sent, DirCount);
    $display("powers of two and extremes); %0d results checked, %0d of them zero over zero.",
             board.reduced, board.zero_pairs);
    if (board.mismatches == 0 && board.pending_fractions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatches,
               board.pending_fractions.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/fr_pkg.sv
rtl/fr_div.sv
rtl/fraction_reduce.sv
tb/fraction_reduce_tb.sv
